>>> src/bfla_pkg.sv
// Shared types and constants for the beacon frame level averager.
`default_nettype none

package bfla_pkg;

    localparam int DATA_W      = 8;
    localparam int SRC_W       = 3;
    localparam int FC_W        = 16;
    localparam int LEVEL_W     = 20;
    localparam int SUM_W       = 24;
    localparam int SCALE_W     = 12;
    localparam int NUM_SOURCES = 4;
    localparam int SRC_IDX_W   = 2;
    localparam int WIN_PRIOR   = 7;
    localparam int FILL_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int OUT_DATA_W  = 40;

    localparam logic [DATA_W-1:0]    DIGIT_ZERO  = 8'd48;
    localparam logic [DATA_W-1:0]    HEAD_RESET  = 8'hCA;
    localparam logic [DATA_W-1:0]    TAIL_RESET  = 8'hFE;
    localparam logic [SCALE_W-1:0]   SCALE_RESET = 12'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;

    // one queued operation: a counted frame, an end of buffer, or both
    typedef struct packed {
        logic                 frame;
        logic [SRC_IDX_W-1:0] src_idx;
        logic [DATA_W-1:0]    level;
        logic                 eob;
    } op_t;

endpackage

`default_nettype wire

>>> src/bfla_front.sv
// Byte window, frame match and source decode; emits operations to the queue.
`default_nettype none

module bfla_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bfla_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                          end_of_buffer,
    input  wire logic [bfla_pkg::DATA_W-1:0]   head_byte,
    input  wire logic [bfla_pkg::DATA_W-1:0]   tail_byte,
    input  wire logic                          queue_full,
    output logic                               push,
    output bfla_pkg::op_t                      push_op
);

    logic [bfla_pkg::DATA_W-1:0] prior_reg [bfla_pkg::WIN_PRIOR];
    logic [bfla_pkg::FILL_W-1:0] fill_reg;

    logic              accept;
    logic              hit;
    logic              src_ok;
    logic signed [12:0] hi_s;
    logic signed [12:0] lo_s;
    logic signed [12:0] src_s;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign hit = (fill_reg == bfla_pkg::FILL_W'(bfla_pkg::WIN_PRIOR)) &&
                 (prior_reg[0] == head_byte) && (data_byte == tail_byte);

    // source = (b1 - '0') * 10 + (b2 - '0'), signed
    assign hi_s  = $signed({5'b0, prior_reg[1]}) - $signed({5'b0, bfla_pkg::DIGIT_ZERO});
    assign lo_s  = $signed({5'b0, prior_reg[2]}) - $signed({5'b0, bfla_pkg::DIGIT_ZERO});
    assign src_s = (hi_s <<< 3) + (hi_s <<< 1) + lo_s;

    assign src_ok = (src_s >= 13'sd1) &&
                    (src_s <= $signed(13'(bfla_pkg::NUM_SOURCES)));

    assign push = accept && ((hit && src_ok) || end_of_buffer);

    always_comb
    begin
        push_op.frame   = hit && src_ok;
        push_op.src_idx = bfla_pkg::SRC_IDX_W'(src_s - 13'sd1);
        push_op.level   = prior_reg[6];
        push_op.eob     = end_of_buffer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            if (hit || end_of_buffer)
            begin
                fill_reg <= '0;
            end
            else if (fill_reg != bfla_pkg::FILL_W'(bfla_pkg::WIN_PRIOR))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // window bytes; fill count says which are meaningful
    always_ff @(posedge clk)
    begin
        if (accept && !hit && !end_of_buffer)
        begin
            if (fill_reg != bfla_pkg::FILL_W'(bfla_pkg::WIN_PRIOR))
            begin
                prior_reg[fill_reg] <= data_byte;
            end
            else
            begin
                for (int i = 0; i < bfla_pkg::WIN_PRIOR - 1; i++)
                begin
                    prior_reg[i] <= prior_reg[i+1];
                end
                prior_reg[bfla_pkg::WIN_PRIOR-1] <= data_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/bfla_queue.sv
// Short operation queue between front and back.
`default_nettype none

module bfla_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bfla_pkg::op_t  push_op,
    output logic                full,
    input  wire logic           pop,
    output bfla_pkg::op_t       pop_op,
    output logic                empty
);

    bfla_pkg::op_t                 entry_reg [bfla_pkg::QUEUE_DEPTH];
    logic [bfla_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [bfla_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [bfla_pkg::QUEUE_AW:0]   count_reg;

    assign full   = (count_reg == (bfla_pkg::QUEUE_AW+1)'(bfla_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

>>> src/bfla_back.sv
// Per-source counters and sums, scaled average by shift-subtract divider.
`default_nettype none

module bfla_back
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           queue_empty,
    input  wire bfla_pkg::op_t                  pop_op,
    output logic                                pop,
    input  wire logic [bfla_pkg::SCALE_W-1:0]   scale_q4,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bfla_pkg::SRC_W-1:0]          source_id,
    output logic [bfla_pkg::FC_W-1:0]           frame_count,
    output logic [bfla_pkg::LEVEL_W-1:0]        level_q4,
    output logic                                last_of_run
);

    localparam int CW     = COUNT_BITS;
    localparam int RW     = COUNT_BITS + 1;
    localparam int PROD_W = bfla_pkg::SUM_W + bfla_pkg::SCALE_W;
    localparam int QW     = bfla_pkg::LEVEL_W;
    localparam int STEP_W = $clog2(QW);
    localparam int FCX_W  = (COUNT_BITS > bfla_pkg::FC_W) ? COUNT_BITS : bfla_pkg::FC_W;

    localparam logic [CW-1:0]     CNT_MAX  = {CW{1'b1}};
    localparam logic [1:0]        ST_IDLE  = 2'd0;
    localparam logic [1:0]        ST_MUL   = 2'd1;
    localparam logic [1:0]        ST_DIV   = 2'd2;
    localparam logic [1:0]        ST_OUT   = 2'd3;
    localparam logic [bfla_pkg::SRC_IDX_W-1:0] LAST_IDX =
        bfla_pkg::SRC_IDX_W'(bfla_pkg::NUM_SOURCES - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [bfla_pkg::SRC_IDX_W-1:0]  k_reg;
    logic [CW-1:0]                   cnt_reg [bfla_pkg::NUM_SOURCES];
    logic [bfla_pkg::SUM_W-1:0]      sum_reg [bfla_pkg::NUM_SOURCES];
    logic [RW-1:0]                   rem_reg;
    logic [QW-1:0]                   qr_reg;
    logic [CW-1:0]                   div_cnt_reg;
    logic                            zero_reg;
    logic [STEP_W-1:0]               step_reg;

    logic                            out_valid_reg;
    logic [bfla_pkg::SRC_W-1:0]      out_src_reg;
    logic [bfla_pkg::FC_W-1:0]       out_fc_reg;
    logic [bfla_pkg::LEVEL_W-1:0]    out_level_reg;
    logic                            out_last_reg;

    logic [bfla_pkg::SRC_IDX_W-1:0]  addr;
    logic [CW-1:0]                   cnt_sel;
    logic [bfla_pkg::SUM_W-1:0]      sum_sel;
    logic [bfla_pkg::SUM_W:0]        sum_add;
    logic [bfla_pkg::SUM_W-1:0]      sum_new;
    logic                            count_it;
    logic [PROD_W-1:0]               prod;
    logic [RW-1:0]                   trial;
    logic                            ge;
    logic                            out_load;
    logic [FCX_W-1:0]                fc_ext;
    logic [bfla_pkg::FC_W-1:0]       fc_sat;

    // single read address: queued op while idle, run index otherwise
    assign addr    = (state_reg == ST_IDLE) ? pop_op.src_idx : k_reg;
    assign cnt_sel = cnt_reg[addr];
    assign sum_sel = sum_reg[addr];

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign count_it = pop && pop_op.frame && (cnt_sel != CNT_MAX);
    assign sum_add  = {1'b0, sum_sel} + (bfla_pkg::SUM_W+1)'(pop_op.level);
    assign sum_new  = sum_add[bfla_pkg::SUM_W] ? {bfla_pkg::SUM_W{1'b1}}
                                               : sum_add[bfla_pkg::SUM_W-1:0];

    assign prod  = PROD_W'(sum_sel) * PROD_W'(scale_q4);
    assign trial = {rem_reg[RW-2:0], qr_reg[QW-1]};
    assign ge    = (trial >= {1'b0, div_cnt_reg});

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign fc_ext = FCX_W'(div_cnt_reg);
    assign fc_sat = (fc_ext > FCX_W'(17'h0FFFF)) ? {bfla_pkg::FC_W{1'b1}}
                                                 : fc_ext[bfla_pkg::FC_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && pop_op.eob)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(QW - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = (k_reg == LAST_IDX) ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < bfla_pkg::NUM_SOURCES; i++)
            begin
                cnt_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (pop && pop_op.eob)
            begin
                k_reg <= '0;
            end
            else if (out_load)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (count_it)
            begin
                cnt_reg[addr] <= cnt_sel + 1'b1;
                sum_reg[addr] <= sum_new;
            end
            else if (out_load && (k_reg == LAST_IDX))
            begin
                for (int i = 0; i < bfla_pkg::NUM_SOURCES; i++)
                begin
                    cnt_reg[i] <= '0;
                    sum_reg[i] <= '0;
                end
            end
        end
    end

    // divider datapath: quotient is known to fit LEVEL_W bits, so the upper
    // product bits start as the partial remainder
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MUL:
            begin
                rem_reg     <= RW'(prod >> QW);
                qr_reg      <= prod[QW-1:0];
                div_cnt_reg <= cnt_sel;
                zero_reg    <= (cnt_sel == '0);
                step_reg    <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= ge ? (trial - {1'b0, div_cnt_reg}) : trial;
                qr_reg   <= {qr_reg[QW-2:0], ge};
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_src_reg   <= {1'b0, k_reg} + 3'd1;
            out_fc_reg    <= fc_sat;
            out_level_reg <= zero_reg ? '0 : qr_reg;
            out_last_reg  <= (k_reg == LAST_IDX);
        end
    end

    assign out_valid   = out_valid_reg;
    assign source_id   = out_src_reg;
    assign frame_count = out_fc_reg;
    assign level_q4    = out_level_reg;
    assign last_of_run = out_last_reg;

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while result run in progress");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_fc_reg == '0)) |-> (out_level_reg == '0))
        else $error("nonzero level for source without frames");

    a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_src_reg == 3'd4)))
        else $error("run end flag not on final source");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (k_reg == LAST_IDX)) |=> (cnt_reg[0] == '0 && sum_reg[0] == '0))
        else $error("source totals not cleared at run end");

endmodule

`default_nettype wire

>>> src/beacon_frame_level_averager.sv
// Beacon frame level averager: top level with config registers and stream ports.
// Input: one byte transfer per cycle while the 4-entry operation queue has room.
// Buffer end: four results, one per source, each from a product step, 20 divide
// steps and the output register; the next source starts once a result is loaded.
// Reset (rst_n, async low): window, counts, sums and queue cleared; config
// registers return to head 0xCA, tail 0xFE, scale 64 (4.0).
`default_nettype none

module beacon_frame_level_averager
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // received bytes
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bfla_pkg::DATA_W-1:0]         s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tlast,   // end_of_buffer
    // per-source results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] source_id, [18:3] frame_count, [38:19] level_q4, [39] zero
    output logic [bfla_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                     m_tlast,   // last_of_run
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bfla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bfla_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [bfla_pkg::DATA_W-1:0]  head_reg;
    logic [bfla_pkg::DATA_W-1:0]  tail_reg;
    logic [bfla_pkg::SCALE_W-1:0] scale_reg;

    logic                         push;
    bfla_pkg::op_t                push_op;
    logic                         queue_full;
    logic                         queue_empty;
    logic                         pop;
    bfla_pkg::op_t                pop_op;

    logic [bfla_pkg::SRC_W-1:0]   source_id;
    logic [bfla_pkg::FC_W-1:0]    frame_count;
    logic [bfla_pkg::LEVEL_W-1:0] level_q4;

    // registers always take a write; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= bfla_pkg::HEAD_RESET;
            tail_reg  <= bfla_pkg::TAIL_RESET;
            scale_reg <= bfla_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfla_pkg::REG_HEAD:  head_reg  <= cfg_data[bfla_pkg::DATA_W-1:0];
                bfla_pkg::REG_TAIL:  tail_reg  <= cfg_data[bfla_pkg::DATA_W-1:0];
                bfla_pkg::REG_SCALE: scale_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: sliding window and frame match, one byte per cycle while the queue has room
    bfla_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .data_byte     (s_tdata),
        .end_of_buffer (s_tlast),
        .head_byte     (head_reg),
        .tail_byte     (tail_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_op       (push_op)
    );

    // decouples byte intake from the slow result run
    bfla_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (queue_empty)
    );

    // back: totals per source and the averaging run
    bfla_back
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_op      (pop_op),
        .pop         (pop),
        .scale_q4    (scale_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .source_id   (source_id),
        .frame_count (frame_count),
        .level_q4    (level_q4),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {1'b0, level_q4, frame_count, source_id};

endmodule

`default_nettype wire

>>> sim/beacon_frame_level_averager_test.sv
// Self-checking testbench for the beacon frame level averager.
`timescale 1ns / 100ps

module beacon_frame_level_averager_test;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 600;       // long receiver hold-off
    localparam int TIMEOUT_NS    = 400_000;   // watchdog limit for the whole sequence
    localparam logic [bfla_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3; // unmapped, write dropped
    localparam logic [bfla_pkg::FC_W-1:0]      FRAMES_MAX = {bfla_pkg::FC_W{1'b1}};
    localparam logic [bfla_pkg::SUM_W-1:0]     SUM_CEIL   = {bfla_pkg::SUM_W{1'b1}};

    // one received byte waiting to be offered
    typedef struct {
        logic [bfla_pkg::DATA_W-1:0] data;
        logic                        eob;
    } rx_byte_t;

    // one per-source report as the block should emit it
    typedef struct {
        logic [bfla_pkg::SRC_W-1:0]   source_id;
        logic [bfla_pkg::FC_W-1:0]    frame_count;
        logic [bfla_pkg::LEVEL_W-1:0] level_q4;
        logic                         last_of_run;
    } source_report_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,        // always ready
        RX_COIN,        // ready half the time
        RX_SPARSE,      // ready one cycle in eight
        RX_EVERY_THIRD  // ready when the tick count is a multiple of three
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bfla_pkg::DATA_W-1:0]     s_tdata   = '0;   // [7:0] data_byte
    logic                            s_tlast   = 1'b0; // end_of_buffer
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bfla_pkg::OUT_DATA_W-1:0] m_tdata;  // [2:0] source, [18:3] count, [38:19] level
    logic                            m_tlast;  // last_of_run
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bfla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bfla_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and expectation stores
    rx_byte_t       tx_bytes[$];
    source_report_t pending_reports[$];
    int             bytes_queued   = 0;
    int             bytes_accepted = 0;
    int             errors         = 0;

    // sender shaping, owned by the sender process; steady set by the sequence
    int   burst_left = 0;
    int   gap_left   = 0;
    logic steady     = 1'b0;

    // receiver shaping; pressure_on set by the sequence, the rest by the receiver
    logic     pressure_on   = 1'b0;
    logic     pressure_done = 1'b0;
    int       hold_count    = 0;
    int       mode_left     = 0;
    int       rx_tick       = 0;
    rx_mode_t stall_mode    = RX_OPEN;

    // predictor state: registers, window, per-source tallies
    logic [bfla_pkg::DATA_W-1:0]  head_reg  = bfla_pkg::HEAD_RESET;
    logic [bfla_pkg::DATA_W-1:0]  tail_reg  = bfla_pkg::TAIL_RESET;
    logic [bfla_pkg::SCALE_W-1:0] scale_reg = bfla_pkg::SCALE_RESET;
    logic [bfla_pkg::DATA_W-1:0]  win[bfla_pkg::WIN_PRIOR];
    int                           win_fill  = 0;
    logic [bfla_pkg::FC_W-1:0]    frames[bfla_pkg::NUM_SOURCES];
    logic [bfla_pkg::SUM_W-1:0]   sums[bfla_pkg::NUM_SOURCES];

    beacon_frame_level_averager dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Feeds one accepted byte through the predicted window and tallies. A byte
    // that completes head..tail empties the window instead of shifting in. On
    // end of buffer the four source reports are queued and everything cleared.
    task automatic absorb_byte(input logic [bfla_pkg::DATA_W-1:0] b, input logic eob);
        int                           src;
        int                           k;
        logic [bfla_pkg::SUM_W:0]     grown;
        logic [63:0]                  lvl;
        source_report_t               r;
        if (win_fill == bfla_pkg::WIN_PRIOR && win[0] == head_reg && b == tail_reg)
        begin
            src = (int'(win[1]) - int'(bfla_pkg::DIGIT_ZERO)) * 10
                + (int'(win[2]) - int'(bfla_pkg::DIGIT_ZERO));
            // sources outside 1..4 still close the frame but are not counted
            if (src >= 1 && src <= bfla_pkg::NUM_SOURCES && frames[src-1] != FRAMES_MAX)
            begin
                grown         = {1'b0, sums[src-1]} + win[6];
                frames[src-1] = frames[src-1] + 1'b1;
                sums[src-1]   = grown[bfla_pkg::SUM_W] ? SUM_CEIL
                                                       : grown[bfla_pkg::SUM_W-1:0];
            end
            win_fill = 0;
            for (k = 0; k < bfla_pkg::WIN_PRIOR; k++) win[k] = '0;
        end
        else if (win_fill < bfla_pkg::WIN_PRIOR)
        begin
            win[win_fill] = b;
            win_fill++;
        end
        else
        begin
            for (k = 0; k < bfla_pkg::WIN_PRIOR - 1; k++) win[k] = win[k+1];
            win[bfla_pkg::WIN_PRIOR-1] = b;
        end
        if (eob)
        begin
            for (k = 0; k < bfla_pkg::NUM_SOURCES; k++)
            begin
                lvl = 64'd0;
                if (frames[k] != 0)
                    lvl = (64'(sums[k]) * 64'(scale_reg)) / 64'(frames[k]);
                r.source_id   = bfla_pkg::SRC_W'(k + 1);
                r.frame_count = frames[k];
                r.level_q4    = lvl[bfla_pkg::LEVEL_W-1:0];
                r.last_of_run = (k == bfla_pkg::NUM_SOURCES - 1);
                pending_reports.insert(pending_reports.size(), r);
                frames[k] = '0;
                sums[k]   = '0;
            end
            win_fill = 0;
            for (k = 0; k < bfla_pkg::WIN_PRIOR; k++) win[k] = '0;
        end
    endtask

    // Sender: bursts of random length, random gaps; holds a byte until taken.
    always @(posedge clk)
    begin : sender
        rx_byte_t cur;
        logic     offer;
        offer = s_tvalid;
        if (!rst_n)
            offer = 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata, s_tlast);
                bytes_accepted++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (tx_bytes.size() != 0)
                begin
                    cur = tx_bytes.pop_front();
                    s_tdata <= cur.data;
                    s_tlast <= cur.eob;
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if (steady)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(6, 20);
                        else
                            gap_left = $urandom_range(0, 3);
                    end
                end
            end
        end
        s_tvalid <= offer;
    end

    // Receiver: switches stall pattern at random times; on request it
    // holds off for HOLD_CYCLES so the block backs up and stops taking bytes.
    always @(posedge clk)
    begin : receiver
        logic rdy;
        rdy = 1'b0;
        rx_tick++;
        if (rst_n)
        begin
            if (pressure_on && !pressure_done)
            begin
                if (hold_count == HOLD_CYCLES)
                begin
                    pressure_done = 1'b1;
                    rdy = 1'b1;
                end
                else
                    hold_count++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 128);
                end
                else
                    mode_left--;
                case (stall_mode)
                    RX_OPEN:        rdy = 1'b1;
                    RX_COIN:        rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE:      rdy = ($urandom_range(0, 7) == 0);
                    RX_EVERY_THIRD: rdy = (rx_tick % 3 == 0);
                    default:        rdy = 1'b1;
                endcase
            end
        end
        m_tready <= rdy;
    end

    // Result check against the oldest queued report, field by field.
    always @(posedge clk)
    begin : result_check
        source_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_tdata[2:0] !== want.source_id)
                begin
                    $display("%0t: source_id: expected %0d, actual %0d",
                             $time, want.source_id, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[18:3] !== want.frame_count)
                begin
                    $display("%0t: frame_count (source %0d): expected %0d, actual %0d",
                             $time, want.source_id, want.frame_count, m_tdata[18:3]);
                    errors++;
                end
                if (m_tdata[38:19] !== want.level_q4)
                begin
                    $display("%0t: level_q4 (source %0d): expected %0d, actual %0d",
                             $time, want.source_id, want.level_q4, m_tdata[38:19]);
                    errors++;
                end
                if (m_tlast !== want.last_of_run)
                begin
                    $display("%0t: last_of_run (source %0d): expected %b, actual %b",
                             $time, want.source_id, want.last_of_run, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Register write over the config channel; predictor copy follows on the
    // accepting edge. Only used while no byte or report is in flight.
    task automatic write_reg(input logic [bfla_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfla_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            bfla_pkg::REG_HEAD:  head_reg  = value[bfla_pkg::DATA_W-1:0];
            bfla_pkg::REG_TAIL:  tail_reg  = value[bfla_pkg::DATA_W-1:0];
            bfla_pkg::REG_SCALE: scale_reg = value;
            default:   ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // head/tail writes carry random upper bits, which the block must drop
    task automatic set_regs(input logic [bfla_pkg::DATA_W-1:0] h,
                            input logic [bfla_pkg::DATA_W-1:0] t,
                            input logic [bfla_pkg::SCALE_W-1:0] sc);
        write_reg(bfla_pkg::REG_HEAD, {4'($urandom_range(0, 15)), h});
        write_reg(bfla_pkg::REG_TAIL, {4'($urandom_range(0, 15)), t});
        write_reg(bfla_pkg::REG_SCALE, sc);
    endtask

    task automatic push_byte(input logic [bfla_pkg::DATA_W-1:0] b, input logic eob);
        rx_byte_t item;
        item.data = b;
        item.eob  = eob;
        tx_bytes.insert(tx_bytes.size(), item);
        bytes_queued++;
    endtask

    // head, two source digits, three filler bytes, level, tail (or a wrong tail)
    task automatic push_frame(input logic [bfla_pkg::DATA_W-1:0] hi,
                              input logic [bfla_pkg::DATA_W-1:0] lo,
                              input logic [bfla_pkg::DATA_W-1:0] level,
                              input logic eob_on_tail,
                              input logic tail_ok);
        push_byte(head_reg, 1'b0);
        push_byte(hi, 1'b0);
        push_byte(lo, 1'b0);
        repeat (3) push_byte(bfla_pkg::DATA_W'($urandom), 1'b0);
        push_byte(level, 1'b0);
        push_byte(tail_ok ? tail_reg : ~tail_reg, eob_on_tail);
    endtask

    // Mostly well-formed frames for sources 1..4 with random levels, mixed
    // with out-of-range sources, stray bytes and frames with a bad tail.
    task automatic random_buffer(input int nframes);
        int                          f;
        int                          kind;
        logic                        end_on_tail;
        logic                        last;
        logic [bfla_pkg::DATA_W-1:0] hi;
        logic [bfla_pkg::DATA_W-1:0] lo;
        end_on_tail = $urandom_range(0, 1);
        for (f = 0; f < nframes; f++)
        begin
            kind = $urandom_range(0, 9);
            last = end_on_tail && (f == nframes - 1);
            hi   = bfla_pkg::DIGIT_ZERO;
            lo   = bfla_pkg::DIGIT_ZERO
                 + bfla_pkg::DATA_W'($urandom_range(1, bfla_pkg::NUM_SOURCES));
            if (kind == 6)
            begin
                hi = bfla_pkg::DATA_W'($urandom);
                lo = bfla_pkg::DATA_W'($urandom);
            end
            else if (kind == 7)
                lo = $urandom_range(0, 1) ? bfla_pkg::DIGIT_ZERO
                                          : bfla_pkg::DIGIT_ZERO + 8'd5;
            else if (kind == 8)
                repeat ($urandom_range(1, 5)) push_byte(bfla_pkg::DATA_W'($urandom), 1'b0);
            push_frame(hi, lo, bfla_pkg::DATA_W'($urandom), last, kind != 9);
        end
        if (!end_on_tail)
        begin
            repeat ($urandom_range(0, 3)) push_byte(bfla_pkg::DATA_W'($urandom), 1'b0);
            push_byte(bfla_pkg::DATA_W'($urandom), 1'b1);
        end
    endtask

    // Wait for every queued byte to be taken and every report to arrive, then
    // let the block drain whatever byte-only work is still inside it.
    task automatic settle();
        while (bytes_accepted != bytes_queued || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : sequence_run
        int k;
        int p;
        for (k = 0; k < bfla_pkg::WIN_PRIOR; k++) win[k] = '0;
        for (k = 0; k < bfla_pkg::NUM_SOURCES; k++)
        begin
            frames[k] = '0;
            sums[k]   = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, reset register values. Buffer end on an empty buffer;
        // sources 1 and 4 at level extremes; then a window that never fills.
        push_byte(8'h00, 1'b1);
        push_frame(bfla_pkg::DIGIT_ZERO, bfla_pkg::DIGIT_ZERO + 8'd1, 8'h00, 1'b0, 1'b1);
        push_frame(bfla_pkg::DIGIT_ZERO, bfla_pkg::DIGIT_ZERO + 8'd4, 8'hFF, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(head_reg, 1'b0);
        push_byte(bfla_pkg::DIGIT_ZERO, 1'b0);
        push_byte(bfla_pkg::DIGIT_ZERO + 8'd2, 1'b1);
        settle();

        // Random phases across register settings, extremes included.
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: set_regs(8'h00, 8'hFF, '0);
                1: set_regs(8'hFF, 8'h00, {bfla_pkg::SCALE_W{1'b1}});
                2: set_regs(bfla_pkg::DATA_W'($urandom), bfla_pkg::DATA_W'($urandom),
                            bfla_pkg::SCALE_W'($urandom));
                default:
                begin
                    k = $urandom_range(0, 255);
                    set_regs(bfla_pkg::DATA_W'(k), bfla_pkg::DATA_W'(k),
                             bfla_pkg::SCALE_W'($urandom));
                end
            endcase
            write_reg(REG_SPARE, bfla_pkg::CFG_DATA_W'($urandom));
            steady = (p == 2);
            repeat (2) random_buffer($urandom_range(1, 2));
            settle();
        end

        // Back-pressure: receiver holds off while short buffers keep coming.
        set_regs(bfla_pkg::HEAD_RESET, bfla_pkg::TAIL_RESET, bfla_pkg::SCALE_W'($urandom));
        steady      = 1'b1;
        pressure_on = 1'b1;
        for (k = 0; k < 8; k++)
            push_frame(bfla_pkg::DIGIT_ZERO,
                       bfla_pkg::DIGIT_ZERO + 8'(1 + k % bfla_pkg::NUM_SOURCES),
                       bfla_pkg::DATA_W'($urandom), 1'b1, 1'b1);
        settle();

        // Full level at full scale: source 1 reaches the widest level value.
        set_regs(bfla_pkg::HEAD_RESET, bfla_pkg::TAIL_RESET, {bfla_pkg::SCALE_W{1'b1}});
        push_frame(bfla_pkg::DIGIT_ZERO, bfla_pkg::DIGIT_ZERO + 8'd1, 8'hFF, 1'b0, 1'b1);
        push_frame(bfla_pkg::DIGIT_ZERO, bfla_pkg::DIGIT_ZERO + 8'd2, 8'h01, 1'b1, 1'b1);
        settle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/bfla_pkg.sv
src/bfla_front.sv
src/bfla_queue.sv
src/bfla_back.sv
src/beacon_frame_level_averager.sv
sim/beacon_frame_level_averager_test.sv
